>>> sv/wodt_pkg.sv
// ----------------------------------------------------------------------------
// wodt_pkg
// shared types and constants for the wheel odometry distance tracker
// ----------------------------------------------------------------------------
package wodt_pkg;

  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned MUL_STEPS = 24;

  localparam logic [63:0] UM_CAP   = 64'h2000_0000_0000_0000;
  localparam logic [15:0] MM_DIV   = 16'd1000;
  localparam logic [15:0] CPR_RST  = 16'd1024;
  localparam logic [23:0] CIRC_RST = 24'd200000;

  localparam logic CFG_CPR  = 1'b0;
  localparam logic CFG_CIRC = 1'b1;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CONV  = 9'b000000010,
    ST_QDIV  = 9'b000000100,
    ST_QMUL  = 9'b000001000,
    ST_RMUL  = 9'b000010000,
    ST_RDIV  = 9'b000100000,
    ST_MMGO  = 9'b001000000,
    ST_MMDIV = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

endpackage

>>> sv/wodt_div.sv
// ----------------------------------------------------------------------------
// wodt_div
// bit-serial restoring divider, 64-bit dividend by 16-bit divisor
// ----------------------------------------------------------------------------
module wodt_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [63:0] quo,
  output logic [15:0] rem
);
  import wodt_pkg::*;

  logic [63:0] quo_r;
  logic [15:0] rem_r;
  logic [15:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[63]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= 7'(DIV_STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[15:0] : trial[15:0];
        quo_r <= {quo_r[62:0], ge};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> sv/wodt_mul.sv
// ----------------------------------------------------------------------------
// wodt_mul
// shift-add multiplier, 64-bit operand by 24-bit circumference
// ----------------------------------------------------------------------------
module wodt_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [23:0] b,
  output logic        done,
  output logic [87:0] prod
);
  import wodt_pkg::*;

  logic [87:0] acc_r;
  logic [87:0] a_r;
  logic [23:0] b_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r  <= '0;
        a_r    <= {24'd0, a};
        b_r    <= b;
        cnt_r  <= 5'(MUL_STEPS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r   <= {a_r[86:0], 1'b0};
        b_r   <= {1'b0, b_r[23:1]};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

>>> sv/wheel_odometry_distance_tracker.sv
// ----------------------------------------------------------------------------
// wheel_odometry_distance_tracker
// differential wheel encoder odometry with millimeter distance outputs
// ----------------------------------------------------------------------------
// An update word runs through the shared bit-serial divider (64 steps per
// division, thirteen divisions per update: two per wheel count conversion and
// one per millimeter value) and the 24-step shift-add multiplier (two products
// per wheel count) before its result word can be taken; a clear or a duplicate
// sequence presents its result word in the cycle after acceptance. The input is
// not ready until the result word is taken, so a stalled output holds off input.
module wheel_odometry_distance_tracker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [23:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // left count change, right count change, sequence number, timestamp
  input  logic [95:0]  in_tdata,
  // operation
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_mm, right_mm, center_mm, total_mm, difference_mm, updates_done,
  // last_time_ms, last_sequence
  output logic [255:0] out_tdata,
  // accepted, status_valid
  output logic [1:0]   out_tuser
);
  import wodt_pkg::*;

  state_t      state_r;
  logic [15:0] cpr_r;
  logic [23:0] circ_r;
  logic [63:0] tot_r [4];
  logic [63:0] um_r [4];
  logic [31:0] hm_r [5];
  logic [31:0] seq_r, time_r, tally_r;
  logic        have_r, vflag_r, acc_r;
  logic [1:0]  k_r;
  logic [2:0]  j_r;
  logic [87:0] prod_r;
  logic        div_go_r, mul_go_r;
  logic [63:0] div_a_r, mul_a_r;
  logic [15:0] div_b_r;

  logic        div_done, mul_done;
  logic [63:0] div_quo;
  logic [15:0] div_rem;
  logic [87:0] mul_p;

  wodt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go_r), .dividend(div_a_r),
    .divisor(div_b_r), .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  wodt_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_go_r), .a(mul_a_r), .b(circ_r),
    .done(mul_done), .prod(mul_p)
  );

  logic [15:0] cpr_eff;
  logic [63:0] ld, rd, cd, td;
  logic [16:0] la, ra;
  logic [63:0] dk, kmag, sum, m, half, um_new;
  logic        kneg;
  logic [63:0] val, jmag;
  logic        jneg;
  logic [31:0] mm_new;
  logic        fire, dup;

  assign cpr_eff = (cpr_r == 16'd0) ? 16'd1 : cpr_r;
  assign fire    = in_tvalid && in_tready;
  assign dup     = have_r && (in_tdata[63:32] == seq_r);

  always_comb begin
    ld = {{48{in_tdata[15]}}, in_tdata[15:0]};
    rd = {{48{in_tdata[31]}}, in_tdata[31:16]};
    cd = ld + rd;
    la = in_tdata[15] ? 17'(-{1'b1, in_tdata[15:0]}) : {1'b0, in_tdata[15:0]};
    ra = in_tdata[31] ? 17'(-{1'b1, in_tdata[31:16]}) : {1'b0, in_tdata[31:16]};
    td = 64'(la) + 64'(ra);

    dk   = tot_r[k_r];
    kneg = (k_r != 2'd3) && dk[63];
    kmag = kneg ? -dk : dk;
    sum  = prod_r[63:0] + div_quo;
    m    = (prod_r > {24'd0, UM_CAP} || sum > UM_CAP) ? UM_CAP : sum;
    half = {1'b0, m[63:1]};
    case (k_r)
      2'd0, 2'd1: um_new = kneg ? -m : m;
      2'd2:       um_new = kneg ? -half : half;
      default:    um_new = half;
    endcase

    val  = (j_r == 3'd4) ? (um_r[0] - um_r[1]) : um_r[j_r[1:0]];
    jneg = val[63];
    jmag = jneg ? -val : val;
    if (j_r == 3'd3) begin
      mm_new = (div_quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_quo[31:0];
    end else if (jneg) begin
      mm_new = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : -div_quo[31:0];
    end else begin
      mm_new = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cpr_r    <= CPR_RST;
      circ_r   <= CIRC_RST;
      seq_r    <= '0;
      time_r   <= '0;
      tally_r  <= '0;
      have_r   <= 1'b0;
      vflag_r  <= 1'b0;
      acc_r    <= 1'b0;
      k_r      <= '0;
      j_r      <= '0;
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        tot_r[i] <= '0;
      end
      for (int i = 0; i < 5; i++) begin
        hm_r[i] <= '0;
      end
    end else begin
      div_go_r <= 1'b0;
      mul_go_r <= 1'b0;
      if (cfg_wen) begin
        case (cfg_addr)
          CFG_CPR:  cpr_r  <= cfg_wdata[15:0];
          CFG_CIRC: circ_r <= cfg_wdata;
          default:  ;
        endcase
      end
      case (state_r)
        ST_IDLE: begin
          if (fire) begin
            acc_r   <= 1'b0;
            state_r <= ST_OUT;
            if (in_tuser == OP_CLEAR) begin
              seq_r   <= '0;
              time_r  <= '0;
              tally_r <= '0;
              have_r  <= 1'b0;
              vflag_r <= 1'b0;
              for (int i = 0; i < 4; i++) begin
                tot_r[i] <= '0;
              end
              for (int i = 0; i < 5; i++) begin
                hm_r[i] <= '0;
              end
            end else if (!dup) begin
              tot_r[0] <= tot_r[0] + ld;
              tot_r[1] <= tot_r[1] + rd;
              tot_r[2] <= tot_r[2] + cd;
              tot_r[3] <= tot_r[3] + td;
              seq_r    <= in_tdata[63:32];
              time_r   <= in_tdata[95:64];
              tally_r  <= tally_r + 32'd1;
              have_r   <= 1'b1;
              vflag_r  <= 1'b1;
              acc_r    <= 1'b1;
              k_r      <= '0;
              state_r  <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          div_go_r <= 1'b1;
          div_a_r  <= kmag;
          div_b_r  <= cpr_eff;
          state_r  <= ST_QDIV;
        end
        ST_QDIV: begin
          if (div_done) begin
            mul_go_r <= 1'b1;
            mul_a_r  <= div_quo;
            state_r  <= ST_QMUL;
          end
        end
        ST_QMUL: begin
          if (mul_done) begin
            prod_r   <= mul_p;
            mul_go_r <= 1'b1;
            mul_a_r  <= {48'd0, div_rem};
            state_r  <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          if (mul_done) begin
            div_go_r <= 1'b1;
            div_a_r  <= mul_p[63:0];
            div_b_r  <= cpr_eff;
            state_r  <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_done) begin
            um_r[k_r] <= um_new;
            if (k_r == 2'd3) begin
              j_r     <= '0;
              state_r <= ST_MMGO;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= ST_CONV;
            end
          end
        end
        ST_MMGO: begin
          div_go_r <= 1'b1;
          div_a_r  <= jmag;
          div_b_r  <= MM_DIV;
          state_r  <= ST_MMDIV;
        end
        ST_MMDIV: begin
          if (div_done) begin
            hm_r[j_r] <= mm_new;
            if (j_r == 3'd4) begin
              state_r <= ST_OUT;
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= ST_MMGO;
            end
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {seq_r, time_r, tally_r, hm_r[4], hm_r[3], hm_r[2], hm_r[1], hm_r[0]};
  assign out_tuser  = {vflag_r, acc_r};

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result word is pending");

  a_acc_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tuser[1])
    else $error("accepted update without status_valid");

  a_tally_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[1]) |-> (out_tdata[191:160] == 32'd0))
    else $error("updates counted while status not valid");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking test of the wheel odometry distance tracker: directed table,
// extreme settings, then random update, clear and duplicate samples, checked
// against a local predictor of accumulated counts and millimeter conversion
// ----------------------------------------------------------------------------
module testbench;
  import wodt_pkg::*;

  typedef struct packed {
    logic        op;
    logic [15:0] ld;
    logic [15:0] rd;
    logic [31:0] seq;
    logic [31:0] tms;
  } sample_t;

  typedef struct packed {
    logic        acc;
    logic        sval;
    logic [31:0] l_mm;
    logic [31:0] r_mm;
    logic [31:0] c_mm;
    logic [31:0] t_mm;
    logic [31:0] d_mm;
    logic [31:0] n_upd;
    logic [31:0] t_last;
    logic [31:0] s_last;
  } odo_t;

  typedef struct {
    sample_t s;
    logic    fixed;
    odo_t    o;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic cfg_addr = CFG_CPR;
  logic [23:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic in_tuser = OP_UPDATE;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic [1:0] out_tuser;

  wheel_odometry_distance_tracker i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wen(cfg_wen), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  localparam int LIMIT = 12_000_000;
  localparam int N_RAND = 1030;

  logic [15:0] cpr;
  logic [23:0] circ;
  logic [63:0] tot_l, tot_r, tot_c2, tot_t2;
  logic [31:0] last_seq, last_tms, n_upd;
  logic        have_seq, sval;
  odo_t        held;

  odo_t odo_q[$];
  int   errors = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  bit   hold_rx = 1'b0;
  bit   done_tx = 1'b0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] count_to_um(logic [63:0] mag);
    logic [63:0] c, q, r, v;
    c = (cpr == 0) ? 64'd1 : {48'd0, cpr};
    q = mag / c;
    r = mag % c;
    if (circ != 0 && q > UM_CAP / circ) return UM_CAP;
    v = q * circ + (r * circ) / c;
    return (v > UM_CAP) ? UM_CAP : v;
  endfunction

  function automatic longint signed_um(logic [63:0] raw);
    logic [63:0] m;
    m = count_to_um(raw[63] ? -raw : raw);
    return raw[63] ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic void odo_reset();
    tot_l = 0; tot_r = 0; tot_c2 = 0; tot_t2 = 0;
    last_seq = 0; last_tms = 0; n_upd = 0; have_seq = 0; sval = 0;
    held = '0;
  endfunction

  function automatic odo_t odo_step(sample_t s);
    longint ldv, rdv, lu, ru, cu;
    logic [63:0] tu, tm;
    odo_t o;
    logic acc;
    acc = 1'b0;
    if (s.op == OP_CLEAR) odo_reset();
    else if (!(have_seq && s.seq == last_seq)) begin
      ldv = longint'($signed(s.ld));
      rdv = longint'($signed(s.rd));
      tot_l += ldv;
      tot_r += rdv;
      tot_c2 += ldv + rdv;
      tot_t2 += (ldv < 0 ? -ldv : ldv) + (rdv < 0 ? -rdv : rdv);
      lu = signed_um(tot_l);
      ru = signed_um(tot_r);
      cu = signed_um(tot_c2) / 2;
      tu = count_to_um(tot_t2) / 2;
      tm = tu / 1000;
      held.l_mm = sat32(lu / 1000);
      held.r_mm = sat32(ru / 1000);
      held.c_mm = sat32(cu / 1000);
      held.t_mm = (tm > 64'hffff_ffff) ? 32'hffff_ffff : tm[31:0];
      held.d_mm = sat32((lu - ru) / 1000);
      last_seq = s.seq; last_tms = s.tms; n_upd++;
      sval = 1; have_seq = 1; acc = 1;
    end
    o = held;
    o.acc = acc; o.sval = sval; o.n_upd = n_upd;
    o.t_last = last_tms; o.s_last = last_seq;
    return o;
  endfunction

  task automatic cfg_write(logic a, logic [23:0] v);
    cfg_wen <= 1'b1; cfg_addr <= a; cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (a == CFG_CPR) cpr = v[15:0]; else circ = v;
  endtask

  task automatic wait_drain();
    while (odo_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(sample_t s, bit fixed, odo_t o);
    odo_t p;
    p = odo_step(s);
    odo_q.push_back(fixed ? o : p);
    in_tvalid <= 1'b1;
    in_tuser <= s.op;
    in_tdata <= {s.tms, s.seq, s.rd, s.ld};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  function automatic sample_t rand_sample(logic [31:0] seq);
    sample_t s;
    int k;
    k = $urandom_range(0, 99);
    s.op = (k < 3) ? OP_CLEAR : OP_UPDATE;
    s.ld = 16'($urandom); s.rd = 16'($urandom);
    if ($urandom_range(0, 2) != 0) begin
      s.ld = 16'($urandom_range(0, 600) - 300);
      s.rd = 16'($urandom_range(0, 600) - 300);
    end
    s.seq = (k < 12) ? last_seq : ((k < 15) ? $urandom : seq);
    s.tms = $urandom;
    return s;
  endfunction

  always @(posedge clk) begin
    odo_t exp_o, got;
    if (out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[1], out_tdata[31:0], out_tdata[63:32],
             out_tdata[95:64], out_tdata[127:96], out_tdata[159:128],
             out_tdata[191:160], out_tdata[223:192], out_tdata[255:224]};
      if (odo_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
      end else begin
        exp_o = odo_q.pop_front();
        if (got !== exp_o) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %h got %h", exp_o, got);
        end
      end
    end
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_rx) out_tready <= 1'b0;
      else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 11);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else out_tready <= 1'b1;
    end
  end

  initial begin
    int k;
    while (!done_tx) begin
      @(posedge clk);
      if (cycles == 20000) begin
        hold_rx = 1'b1;
        for (k = 0; k < 5000; k++) @(posedge clk);
        hold_rx = 1'b0;
      end
    end
  end

  row_t tbl[$];
  initial begin
    sample_t s;
    odo_t z;
    logic [31:0] seq;
    int i;
    cpr = CPR_RST; circ = CIRC_RST;
    odo_reset();
    z = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: zero counts still accepted at sequence zero
    tbl.push_back('{'{OP_UPDATE, 16'd0, 16'd0, 32'd0, 32'd5}, 1'b1,
                  '{1'b1, 1'b1, 0, 0, 0, 0, 0, 32'd1, 32'd5, 32'd0}});
    // duplicate sequence held
    tbl.push_back('{'{OP_UPDATE, 16'd7, 16'd7, 32'd0, 32'd9}, 1'b1,
                  '{1'b0, 1'b1, 0, 0, 0, 0, 0, 32'd1, 32'd5, 32'd0}});
    // one revolution each side
    tbl.push_back('{'{OP_UPDATE, 16'd1024, 16'd1024, 32'd1, 32'd10}, 1'b1,
                  '{1'b1, 1'b1, 32'd200, 32'd200, 32'd200, 32'd200, 32'd0,
                    32'd2, 32'd10, 32'd1}});
    tbl.push_back('{'{OP_UPDATE, 16'h8000, 16'h7fff, 32'd2, 32'hffff_ffff}, 1'b0, z});
    tbl.push_back('{'{OP_UPDATE, 16'h7fff, 16'h8000, 32'hffff_ffff, 32'd0}, 1'b0, z});
    tbl.push_back('{'{OP_UPDATE, 16'hffff, 16'h0001, 32'hffff_ffff, 32'd3}, 1'b0, z});
    tbl.push_back('{'{OP_CLEAR, 16'h1234, 16'h5678, 32'd4, 32'd4}, 1'b1, z});
    // after clear the zero sequence is new again
    tbl.push_back('{'{OP_UPDATE, 16'h8000, 16'h8000, 32'd0, 32'd6}, 1'b0, z});
    tbl.push_back('{'{OP_UPDATE, 16'h8000, 16'h7fff, 32'h8000_0000, 32'd7}, 1'b0, z});
    tbl.push_back('{'{OP_CLEAR, 16'd0, 16'd0, 32'd0, 32'd0}, 1'b1, z});
    foreach (tbl[j]) send(tbl[j].s, tbl[j].fixed, tbl[j].o);
    in_tvalid <= 1'b0;
    wait_drain();

    // extreme settings: tiny, zero and large cpr, large, tiny and zero circumference, saturation
    cfg_write(CFG_CPR, 24'd1);
    cfg_write(CFG_CIRC, 24'd10_000_000);
    for (i = 0; i < 6; i++) begin
      s = '{OP_UPDATE, 16'h7fff, 16'h8000, 32'd100 + i, 32'd1};
      send(s, 1'b0, z);
    end
    in_tvalid <= 1'b0;
    wait_drain();
    cfg_write(CFG_CPR, 24'd0);
    cfg_write(CFG_CIRC, 24'hff_ffff);
    send('{OP_UPDATE, 16'h8000, 16'h0001, 32'd200, 32'd2}, 1'b0, z);
    send('{OP_UPDATE, 16'd3, 16'hfffd, 32'd200, 32'd3}, 1'b0, z);
    in_tvalid <= 1'b0;
    wait_drain();
    cfg_write(CFG_CPR, 24'hffff);
    cfg_write(CFG_CIRC, 24'd1);
    send('{OP_UPDATE, 16'h7fff, 16'h7fff, 32'd300, 32'd4}, 1'b0, z);
    in_tvalid <= 1'b0;
    wait_drain();
    cfg_write(CFG_CIRC, 24'd0);
    send('{OP_UPDATE, 16'h7fff, 16'h8000, 32'd301, 32'd5}, 1'b0, z);
    in_tvalid <= 1'b0;
    wait_drain();

    seq = 32'd1000;
    for (i = 0; i < N_RAND; i++) begin
      if (i % 200 == 0) begin
        in_tvalid <= 1'b0;
        wait_drain();
        cfg_write(CFG_CPR, 24'($urandom_range(0, 3) == 0 ? $urandom_range(1, 65535)
                                                         : $urandom_range(1, 4096)));
        cfg_write(CFG_CIRC, 24'($urandom_range(0, 3) == 0 ? $urandom_range(1, 10_000_000)
                                                          : $urandom_range(1, 400000)));
      end
      if (i >= N_RAND - 100) quiet = 1'b1;
      seq = seq + $urandom_range(1, 3);
      s = rand_sample(seq);
      send(s, 1'b0, z);
    end
    in_tvalid <= 1'b0;
    done_tx = 1'b1;
    wait_drain();
    repeat (2200) @(posedge clk);
    if (errors == 0 && odo_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
